>>> rtl/core/assert_macros.svh
// Assertion macros used by the frame history ring RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that an expression holds at every clock edge outside reset.
`define FHR_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a same-cycle implication.
`define FHR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle.
`define FHR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FHR_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define FHR_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define FHR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/core/fhr_pkg.sv
// Shared constants, codes and types of the frame history ring.
package fhr_pkg;

   localparam int DEPTH        = 64;
   localparam int SLOT_BITS    = $clog2(DEPTH);
   localparam int COUNT_BITS   = $clog2(DEPTH + 1);
   localparam int PAYLOAD_BITS = 32;
   localparam int HANDLE_BITS  = 32;
   localparam int ID_BITS      = 32;
   localparam int POS_BITS     = 16;
   localparam int ACTION_BITS  = 2;
   localparam int STATUS_BITS  = 2;
   localparam int ENTRY_BITS   = PAYLOAD_BITS + HANDLE_BITS;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_APPEND   = 2'd0,
      ACT_READ_POS = 2'd1,
      ACT_READ_ID  = 2'd2
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   // Per-request information that travels beside the store read.
   typedef struct packed {
      status_type             status;
      logic [ID_BITS-1:0]     frame_number;
      logic [COUNT_BITS-1:0]  frame_count;
      logic                   has_data;
      logic                   evicted;
   } fhr_meta_type;

endpackage

>>> rtl/core/fhr_channels.sv
// Request and response channel interfaces of the frame history ring.
interface fhr_req_if import fhr_pkg::*; ;
   logic                    valid;
   logic                    ready;
   logic [ACTION_BITS-1:0]  action;
   logic [PAYLOAD_BITS-1:0] event_payload;
   logic [HANDLE_BITS-1:0]  snapshot_handle;
   logic [POS_BITS-1:0]     position;
   logic [ID_BITS-1:0]      wanted_id;

   modport source (
      output valid, action, event_payload, snapshot_handle, position, wanted_id,
      input  ready
   );
   modport sink (
      input  valid, action, event_payload, snapshot_handle, position, wanted_id,
      output ready
   );
endinterface

interface fhr_rsp_if import fhr_pkg::*; ;
   logic                    valid;
   logic                    ready;
   logic [STATUS_BITS-1:0]  status;
   logic [ID_BITS-1:0]      frame_number;
   logic [PAYLOAD_BITS-1:0] read_payload;
   logic [HANDLE_BITS-1:0]  read_handle;
   logic [COUNT_BITS-1:0]   frame_count;
   logic                    evicted_valid;
   logic [HANDLE_BITS-1:0]  evicted_handle;

   modport source (
      output valid, status, frame_number, read_payload, read_handle, frame_count,
             evicted_valid, evicted_handle,
      input  ready
   );
   modport sink (
      input  valid, status, frame_number, read_payload, read_handle, frame_count,
             evicted_valid, evicted_handle,
      output ready
   );
endinterface

>>> rtl/core/fhr_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
module fhr_ram #(
   parameter int DATA_BITS = 64,
   parameter int ENTRIES   = 64,
   localparam int ADDR_BITS = $clog2(ENTRIES)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [ENTRIES];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Write and read; a read of the slot being written returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/fhr_ctrl.sv
// Ring bookkeeping: decodes a request, updates count, oldest slot and next id.
`include "assert_macros.svh"

module fhr_ctrl import fhr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [ACTION_BITS-1:0]  action,
   input  logic [PAYLOAD_BITS-1:0] event_payload,
   input  logic [HANDLE_BITS-1:0]  snapshot_handle,
   input  logic [POS_BITS-1:0]     position,
   input  logic [ID_BITS-1:0]      wanted_id,
   output logic                    wr_en,
   output logic [SLOT_BITS-1:0]    wr_addr,
   output logic [ENTRY_BITS-1:0]   wr_data,
   output logic [SLOT_BITS-1:0]    rd_addr,
   output fhr_meta_type            meta_out
);

   logic [COUNT_BITS-1:0] held_ff, held_in;
   logic [SLOT_BITS-1:0]  oldest_ff, oldest_in;
   logic [ID_BITS-1:0]    next_ff, next_in;

   logic                  full;
   logic                  append_ok;
   logic [ID_BITS-1:0]    oldest_id;
   logic [ID_BITS-1:0]    id_age;
   logic [SLOT_BITS-1:0]  age;
   action_type            act;

   // Add an age to a slot, wrapping at the ring depth
   function automatic logic [SLOT_BITS-1:0] slot_add(
      input logic [SLOT_BITS-1:0] base,
      input logic [SLOT_BITS-1:0] step
   );
      logic [SLOT_BITS:0] sum;
      sum = {1'b0, base} + {1'b0, step};
      if (sum >= (SLOT_BITS+1)'(DEPTH)) begin
         sum = sum - (SLOT_BITS+1)'(DEPTH);
      end
      return sum[SLOT_BITS-1:0];
   endfunction

   assign act       = action_type'(action);
   assign full      = (held_ff == COUNT_BITS'(DEPTH));
   assign oldest_id = next_ff - ID_BITS'(held_ff);
   assign id_age    = wanted_id - oldest_id;
   assign wr_data   = {event_payload, snapshot_handle};
   assign wr_en     = accept && append_ok;

   // Decode the request against the current ring state
   always_comb begin
      held_in   = held_ff;
      oldest_in = oldest_ff;
      next_in   = next_ff;
      append_ok = 1'b0;
      age       = '0;
      wr_addr   = full ? oldest_ff : slot_add(oldest_ff, held_ff[SLOT_BITS-1:0]);
      rd_addr   = oldest_ff;
      meta_out  = '0;
      meta_out.status = ST_OK;
      case (act)
         ACT_APPEND: begin
            if (snapshot_handle == '0) begin
               meta_out.status = ST_INVALID;
            end else if (next_ff == '1) begin
               meta_out.status = ST_OVERFLOW;
            end else begin
               append_ok             = 1'b1;
               meta_out.frame_number = next_ff;
               next_in               = next_ff + ID_BITS'(1);
               if (full) begin
                  meta_out.evicted = 1'b1;
                  oldest_in        = slot_add(oldest_ff, SLOT_BITS'(1));
               end else begin
                  held_in = held_ff + COUNT_BITS'(1);
               end
            end
         end
         ACT_READ_POS: begin
            if (position < POS_BITS'(held_ff)) begin
               age                   = position[SLOT_BITS-1:0];
               rd_addr               = slot_add(oldest_ff, age);
               meta_out.has_data     = 1'b1;
               meta_out.frame_number = oldest_id + ID_BITS'(age);
            end else begin
               meta_out.status = ST_NOT_FOUND;
            end
         end
         ACT_READ_ID: begin
            if (held_ff != '0 && wanted_id >= oldest_id && wanted_id < next_ff) begin
               age                   = id_age[SLOT_BITS-1:0];
               rd_addr               = slot_add(oldest_ff, age);
               meta_out.has_data     = 1'b1;
               meta_out.frame_number = wanted_id;
            end else begin
               meta_out.status = ST_NOT_FOUND;
            end
         end
         default: begin
            meta_out.status = ST_INVALID;
         end
      endcase
      meta_out.frame_count = held_in;
   end

   // Advance ring state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         oldest_ff <= '0;
         next_ff   <= ID_BITS'(1);
      end else if (accept) begin
         held_ff   <= held_in;
         oldest_ff <= oldest_in;
         next_ff   <= next_in;
      end
   end

   `FHR_ASSERT_ALWAYS(a_held_range, clock, reset, held_ff <= COUNT_BITS'(DEPTH), "held count beyond depth")
   `FHR_ASSERT_ALWAYS(a_oldest_range, clock, reset, (SLOT_BITS+1)'(oldest_ff) < (SLOT_BITS+1)'(DEPTH), "oldest slot beyond depth")
   `FHR_ASSERT_NEXT(a_id_step, clock, reset, accept && append_ok, next_ff == $past(next_ff) + ID_BITS'(1), "next id did not advance")
   `FHR_ASSERT_NEXT(a_evict_full, clock, reset, accept && meta_out.evicted, held_ff == COUNT_BITS'(DEPTH), "ring not full after eviction")
   `FHR_ASSERT_IMPL(a_evict_only_full, clock, reset, meta_out.evicted, full && act == ACT_APPEND, "eviction from a ring that is not full")

endmodule

>>> rtl/core/fhr_resp.sv
// Response path: store-read stage, output register and channel handshake.
module fhr_resp import fhr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  accept,
   input  fhr_meta_type          meta_in,
   input  logic [ENTRY_BITS-1:0] rd_data,
   fhr_rsp_if.source             rsp_chan
);

   logic                    p1_valid_ff, p1_valid_in;
   fhr_meta_type            p1_meta_ff;
   logic                    p1_move;

   logic                    out_valid_ff, out_valid_in;
   status_type              out_status_ff;
   logic [ID_BITS-1:0]      out_number_ff;
   logic [PAYLOAD_BITS-1:0] out_payload_ff;
   logic [HANDLE_BITS-1:0]  out_handle_ff;
   logic [COUNT_BITS-1:0]   out_count_ff;
   logic                    out_evicted_ff;
   logic [HANDLE_BITS-1:0]  out_evicted_handle_ff;

   logic [PAYLOAD_BITS-1:0] data_payload;
   logic [HANDLE_BITS-1:0]  data_handle;

   assign data_payload = rd_data[ENTRY_BITS-1:HANDLE_BITS];
   assign data_handle  = rd_data[HANDLE_BITS-1:0];

   // Move the stage forward when the output register is free or draining
   assign p1_move      = p1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_ready    = !p1_valid_ff || p1_move;
   assign accept       = req_valid && req_ready;
   assign p1_valid_in  = accept || (p1_valid_ff && !p1_move);
   assign out_valid_in = p1_move || (out_valid_ff && !rsp_chan.ready);

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture request info beside the store read
   always_ff @(posedge clock) begin
      if (accept) begin
         p1_meta_ff <= meta_in;
      end
   end

   // Load the result; zero the fields that carry no meaning
   always_ff @(posedge clock) begin
      if (p1_move) begin
         out_status_ff         <= p1_meta_ff.status;
         out_number_ff         <= p1_meta_ff.frame_number;
         out_count_ff          <= p1_meta_ff.frame_count;
         out_payload_ff        <= p1_meta_ff.has_data ? data_payload : '0;
         out_handle_ff         <= p1_meta_ff.has_data ? data_handle : '0;
         out_evicted_ff        <= p1_meta_ff.evicted;
         out_evicted_handle_ff <= p1_meta_ff.evicted ? data_handle : '0;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.status         = out_status_ff;
   assign rsp_chan.frame_number   = out_number_ff;
   assign rsp_chan.read_payload   = out_payload_ff;
   assign rsp_chan.read_handle    = out_handle_ff;
   assign rsp_chan.frame_count    = out_count_ff;
   assign rsp_chan.evicted_valid  = out_evicted_ff;
   assign rsp_chan.evicted_handle = out_evicted_handle_ff;

endmodule

>>> rtl/core/frame_history_ring.sv
// Frame history ring: a fixed-depth overwrite ring with reads by age or by id.
// An accepted request passes the store-read stage and then the output register.
// Throughput: one request per cycle while responses are not stalled; the store is read once per request.
// Back-pressure: a stalled response holds one more request in the read stage.
// Reset: synchronous; empties the ring and sets the next id to one.
// The frame store is not cleared; only data from written slots is ever returned.
module frame_history_ring import fhr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   fhr_req_if.sink   req_chan,
   fhr_rsp_if.source rsp_chan
);

   logic                  accept;
   logic                  req_ready;
   logic                  wr_en;
   logic [SLOT_BITS-1:0]  wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic [SLOT_BITS-1:0]  rd_addr;
   logic [ENTRY_BITS-1:0] rd_data;
   fhr_meta_type          meta;

   assign req_chan.ready = req_ready;

   fhr_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .action          (req_chan.action),
      .event_payload   (req_chan.event_payload),
      .snapshot_handle (req_chan.snapshot_handle),
      .position        (req_chan.position),
      .wanted_id       (req_chan.wanted_id),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .meta_out        (meta)
   );

   fhr_ram #(
      .DATA_BITS (ENTRY_BITS),
      .ENTRIES   (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fhr_resp u_resp (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .accept    (accept),
      .meta_in   (meta),
      .rd_data   (rd_data),
      .rsp_chan  (rsp_chan)
   );

endmodule
